/* rtl/iprt_pkg.sv */
`default_nettype none
package iprt_pkg;
  localparam int POOL_ENTRIES = 4096;
  localparam int BUCKETS = 1024;
  localparam int SHORT_MAX_LEN = 12;
  localparam int GROUP_LO = SHORT_MAX_LEN >> 2;
  localparam int GROUPS = 8 - GROUP_LO;
  localparam int SHORT_DEPTH = (2 << SHORT_MAX_LEN) - 2;
  localparam int SHORT_AW = $clog2(SHORT_DEPTH);
  localparam int BUCKET_DEPTH = GROUPS * BUCKETS;
  localparam int BUCKET_AW = $clog2(BUCKET_DEPTH);
  localparam int BKT_BITS = $clog2(BUCKETS);
  localparam int POOL_AW = $clog2(POOL_ENTRIES);
  localparam int LINK_W = POOL_AW + 1;
  localparam int CLR_DEPTH = (SHORT_DEPTH > BUCKET_DEPTH) ? SHORT_DEPTH : BUCKET_DEPTH;
  localparam int CLR_W = $clog2(CLR_DEPTH + 1);

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BADLEN = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_HEAD_RD, S_HEAD_WAIT, S_NODE_RD, S_NODE_WAIT,
    S_NODE_EVAL, S_ALLOC, S_GROUP_NEXT, S_SHORT_RD, S_SHORT_WAIT, S_SHORT_EVAL,
    S_DONE
  } state_t;

  function automatic logic [31:0] prefix_of(input logic [31:0] a, input logic [5:0] len);
    logic [31:0] r;
    r = (len >= 6'd32) ? a : (a >> (6'd32 - len));
    return r;
  endfunction

  function automatic logic [BUCKET_AW-1:0] bucket_of(input logic [2:0] g,
                                                      input logic [31:0] a);
    logic [5:0] base;
    logic [31:0] sh;
    logic [BUCKET_AW-1:0] grp;
    base = {1'b0, g, 2'b00} + 6'd1;
    sh = a >> (6'd32 - base);
    grp = BUCKET_AW'(g - 3'(GROUP_LO));
    return BUCKET_AW'(sh[BKT_BITS-1:0]) + BUCKET_AW'(grp * BUCKET_AW'(BUCKETS));
  endfunction

  function automatic logic [SHORT_AW-1:0] short_index(input logic [31:0] a,
                                                       input logic [5:0] len);
    logic [SHORT_AW:0] base;
    logic [31:0] p;
    base = (SHORT_AW+1)'((1 << len[4:0]) - 2);
    p = prefix_of(a, len);
    return SHORT_AW'(base + p[SHORT_AW:0]);
  endfunction
endpackage
`default_nettype wire

/* rtl/iprt_ram.sv */
`default_nettype none
module iprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/ipv4_route_table_lpm.sv */
// IPv4 route table with longest-prefix lookup.
// Command channel: drive operation, address, prefix_len, out_port and
// next_hop with start high; the transfer happens at an edge where busy is
// low. One result per command appears on found, result_port, result_hop and
// status for exactly one cycle with done high; the receiver cannot stall.
// Routes of length 1..12 live in direct tables, longer ones in a 4096-entry
// pool chained from hash buckets, one bucket set per group of four lengths.
// One sequencer reads one memory word per step through a single compare
// unit. Busy stays high after a transfer while it works: a bad length goes
// straight to done, a direct-table insert reads then writes its entry, a
// new long route walks its bucket chain and then allocates a pool entry (a
// replace stops at the match). A lookup walks hashed groups from the
// longest down, stopping at the first group with a match; if none matches it
// tries direct lengths from 12 down to 1. done is high in the first cycle
// with busy low, and the next transfer may happen in that same cycle.
// After reset a clearing pass empties the direct table valid bits and
// bucket heads; busy stays high during it.
`default_nettype none
module ipv4_route_table_lpm
  import iprt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [31:0] address,
  input  wire logic [5:0]  prefix_len,
  input  wire logic [7:0]  out_port,
  input  wire logic [31:0] next_hop,
  output logic             done,
  output logic             found,
  output logic [7:0]       result_port,
  output logic [31:0]      result_hop,
  output logic [1:0]       status
);
  state_t state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic op;
  logic [31:0] addr, hop;
  logic [5:0] len;
  logic [7:0] port;
  logic [2:0] grp;
  logic [5:0] slen;
  logic [LINK_W-1:0] idx;
  logic [LINK_W-1:0] head;
  logic [5:0] best_len;
  logic [LINK_W:0] used;
  logic [LINK_W:0] steps;

  logic sh_we; logic [SHORT_AW-1:0] sh_wa, sh_ra; logic [40:0] sh_wd, sh_rd;
  logic bk_we; logic [BUCKET_AW-1:0] bk_wa, bk_ra;
  logic [LINK_W-1:0] bk_wd, bk_rd;
  logic pk_we; logic [POOL_AW-1:0] pw_a, pr_a; logic [37:0] pk_wd, pk_rd;
  logic pv_we; logic [39:0] pv_wd, pv_rd;
  logic pl_we; logic [LINK_W-1:0] pl_wd, pl_rd;

  iprt_ram #(.WIDTH(41), .DEPTH(SHORT_DEPTH)) u_short (
    .clk, .we(sh_we), .waddr(sh_wa), .wdata(sh_wd), .raddr(sh_ra), .rdata(sh_rd));
  iprt_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_DEPTH)) u_heads (
    .clk, .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));
  iprt_ram #(.WIDTH(38), .DEPTH(POOL_ENTRIES)) u_keys (
    .clk, .we(pk_we), .waddr(pw_a), .wdata(pk_wd), .raddr(pr_a), .rdata(pk_rd));
  iprt_ram #(.WIDTH(40), .DEPTH(POOL_ENTRIES)) u_vals (
    .clk, .we(pv_we), .waddr(pw_a), .wdata(pv_wd), .raddr(pr_a), .rdata(pv_rd));
  iprt_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_links (
    .clk, .we(pl_we), .waddr(pw_a), .wdata(pl_wd), .raddr(pr_a), .rdata(pl_rd));

  logic [5:0] klen;
  logic key_hit, lk_hit, walk_ok, is_short, len_bad;
  logic [2:0] ins_grp;
  logic [31:0] cmp_a;
  assign klen = pk_rd[37:32];
  assign len_bad = (len == 6'd0) || (len > 6'd32);
  assign is_short = (len <= 6'(SHORT_MAX_LEN));
  assign ins_grp = 3'((len - 6'd1) >> 2);
  // shared compare unit
  assign cmp_a = prefix_of(addr, op == OP_LOOKUP ? klen : len);
  assign key_hit = (pk_rd == {len, cmp_a});
  assign lk_hit = (klen >= 6'd1) && (klen <= 6'd32) && (klen > best_len) &&
                  (3'((klen - 6'd1) >> 2) == grp) && (pk_rd[31:0] == cmp_a);
  assign walk_ok = (idx != '0) && ({1'b0, idx} <= (LINK_W+1)'(POOL_ENTRIES)) &&
                   (steps < (LINK_W+1)'(POOL_ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: if (start) state_next = S_CHECK;
      S_CHECK: begin
        if (op == OP_INSERT && len_bad) state_next = S_DONE;
        else if (op == OP_INSERT && is_short) state_next = S_SHORT_RD;
        else state_next = S_HEAD_RD;
      end
      S_HEAD_RD: state_next = S_HEAD_WAIT;
      S_HEAD_WAIT: state_next = S_NODE_RD;
      S_NODE_RD: begin
        if (walk_ok) state_next = S_NODE_WAIT;
        else if (op == OP_INSERT) state_next = S_ALLOC;
        else state_next = S_GROUP_NEXT;
      end
      S_NODE_WAIT: state_next = S_NODE_EVAL;
      S_NODE_EVAL: begin
        if (op == OP_INSERT && key_hit) state_next = S_DONE;
        else state_next = S_NODE_RD;
      end
      S_ALLOC: state_next = S_DONE;
      S_GROUP_NEXT: begin
        if (best_len != '0) state_next = S_DONE;
        else if (grp == 3'(GROUP_LO)) state_next = S_SHORT_RD;
        else state_next = S_HEAD_RD;
      end
      S_SHORT_RD: state_next = S_SHORT_WAIT;
      S_SHORT_WAIT: state_next = S_SHORT_EVAL;
      S_SHORT_EVAL: begin
        if (op == OP_INSERT || sh_rd[40] || slen == 6'd1) state_next = S_DONE;
        else state_next = S_SHORT_RD;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    sh_we = 1'b0; sh_wa = short_index(addr, len); sh_wd = {1'b1, port, hop};
    sh_ra = short_index(addr, op == OP_INSERT ? len : slen);
    bk_we = 1'b0; bk_wa = bucket_of(op == OP_LOOKUP ? grp : ins_grp, addr);
    bk_ra = bk_wa; bk_wd = LINK_W'(used + 1'b1);
    pk_we = 1'b0; pv_we = 1'b0; pl_we = 1'b0;
    pw_a = POOL_AW'(used); pk_wd = {len, prefix_of(addr, len)};
    pv_wd = {port, hop}; pl_wd = head;
    pr_a = POOL_AW'(idx - 1'b1);
    if (state == S_CLEAR) begin
      sh_we = (clr_cnt < CLR_W'(SHORT_DEPTH)); sh_wa = SHORT_AW'(clr_cnt); sh_wd = '0;
      bk_we = (clr_cnt < CLR_W'(BUCKET_DEPTH)); bk_wa = BUCKET_AW'(clr_cnt); bk_wd = '0;
    end else if (state == S_SHORT_EVAL) begin
      sh_we = (op == OP_INSERT);
    end else if (state == S_NODE_EVAL) begin
      pv_we = (op == OP_INSERT) && key_hit;
      pw_a = POOL_AW'(idx - 1'b1);
    end else if (state == S_ALLOC) begin
      pk_we = (used < (LINK_W+1)'(POOL_ENTRIES));
      pv_we = pk_we; pl_we = pk_we; bk_we = pk_we;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      used <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_DONE);
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_ALLOC && used < (LINK_W+1)'(POOL_ENTRIES)) used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op <= operation; addr <= address; len <= prefix_len;
        port <= out_port; hop <= next_hop;
        grp <= 3'd7; slen <= 6'(SHORT_MAX_LEN);
        best_len <= '0;
        found <= 1'b0; result_port <= '0; result_hop <= '0; status <= ST_ADDED;
      end
      S_CHECK: begin
        if (op == OP_INSERT && len_bad) status <= ST_BADLEN;
      end
      S_HEAD_RD: steps <= '0;
      S_HEAD_WAIT: begin idx <= bk_rd; head <= bk_rd; end
      S_NODE_EVAL: begin
        if (op == OP_INSERT) begin
          if (key_hit) status <= ST_REPLACED;
        end else if (lk_hit) begin
          best_len <= klen;
          result_port <= pv_rd[39:32]; result_hop <= pv_rd[31:0]; found <= 1'b1;
        end
        idx <= pl_rd;
        steps <= steps + 1'b1;
      end
      S_ALLOC: if (used >= (LINK_W+1)'(POOL_ENTRIES)) status <= ST_FULL;
      S_GROUP_NEXT: grp <= grp - 3'd1;
      S_SHORT_EVAL: begin
        if (op == OP_INSERT) begin
          status <= sh_rd[40] ? ST_REPLACED : ST_ADDED;
        end else begin
          if (sh_rd[40]) begin
            found <= 1'b1; result_port <= sh_rd[39:32]; result_hop <= sh_rd[31:0];
          end
          slen <= slen - 6'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
